[hw/rtl/vrar_pkg.sv]
// vrar_pkg: types and constants for the valve relay ack/retry unit
// no dependencies; imported by valve_relay_ack_retry_unit
package vrar_pkg;

	localparam logic [1:0] CMD_UP   = 2'd0;
	localparam logic [1:0] CMD_DOWN = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic       DEST_UP   = 1'b0;
	localparam logic       DEST_DOWN = 1'b1;

	localparam logic       REG_RESEND_WAIT = 1'b0;
	localparam logic       REG_MAX_RESENDS = 1'b1;

	localparam logic [15:0] RESEND_WAIT_RST = 16'd3000;
	localparam logic [3:0]  MAX_RESENDS_RST = 4'd5;
	localparam logic [15:0] OWN_ACK_ON      = 16'd200;
	localparam logic [16:0] ELAPSED_MAX     = 17'h1FFFF;

	// floor(x/100) = (x*83887)>>23 for 16-bit x
	localparam logic [16:0] DIV100_MUL = 17'd83887;
	// floor(q/10) = (q*205)>>11 for q < 1024
	localparam logic [7:0]  DIV10_MUL  = 8'd205;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] msg;
		logic        short_frame;
	} req_t;

	typedef struct packed {
		logic        dest;
		logic [15:0] value;
		logic        valve_open;
		logic        last;
	} rsp_t;

endpackage

[hw/rtl/valve_relay_ack_retry_unit.sv]
// valve_relay_ack_retry_unit: relay node with downstream ack, timeout and resend
// depends on vrar_pkg for request/response types and constants
// path: a request is held in the input register, then its results are written to the output queue
// throughput: one request per cycle while the 4-entry output queue has room for two results;
//   requests with two results are then limited by the drain of one result per cycle
// reset: valve off, not waiting, counters and queue cleared, registers at 3000 and 5
module valve_relay_ack_retry_unit
	import vrar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// input register
	logic        valid_s1;
	req_t        req_s1;
	logic [9:0]  quo_s1;
	logic [32:0] div_prod;

	// configuration
	logic [15:0] resend_wait_q;
	logic [3:0]  max_resends_q;

	// node state
	logic        valve_q;
	logic [6:0]  fwd_q;
	logic        waiting_q;
	logic [16:0] elapsed_q;
	logic [3:0]  resend_q;

	// output queue
	rsp_t        queue_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	logic        fire;
	logic        req_take;
	logic        rsp_take;
	logic [16:0] quo_x100;
	logic [6:0]  rem100;
	logic [17:0] div10_prod;
	logic [6:0]  quo10;
	logic [9:0]  quo10_x10;
	logic [3:0]  digit;
	logic [15:0] own_ack;
	logic [16:0] elapsed_inc;

	logic        valve_d;
	logic [6:0]  fwd_d;
	logic        waiting_d;
	logic [16:0] elapsed_d;
	logic [3:0]  resend_d;
	logic [1:0]  n_res;
	rsp_t        res0;
	rsp_t        res1;
	logic [1:0]  n_push;
	logic        n_pop;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (count_q <= 3'd2);
	assign req_stall = valid_s1 && !fire;
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = (count_q != 3'd0);
	assign rsp_data  = queue_q[rd_ptr_q];
	assign rsp_take  = rsp_valid && !rsp_stall;

	assign div_prod = {17'd0, req_data.msg} * {16'd0, DIV100_MUL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req_data;
			quo_s1 <= div_prod[32:23];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_wait_q <= RESEND_WAIT_RST;
			max_resends_q <= MAX_RESENDS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RESEND_WAIT: resend_wait_q <= cfg_data;
				REG_MAX_RESENDS: max_resends_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// decimal split of the registered frame value
	assign quo_x100   = {7'd0, quo_s1} * 17'd100;
	assign rem100     = 7'(req_s1.msg - quo_x100[15:0]);
	assign div10_prod = {8'd0, quo_s1} * {10'd0, DIV10_MUL};
	assign quo10      = div10_prod[17:11];
	assign quo10_x10  = {3'd0, quo10} * 10'd10;
	assign digit      = 4'(quo_s1 - quo10_x10);

	assign own_ack     = valve_q ? OWN_ACK_ON : 16'd0;
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 17'd1;

	always_comb begin
		valve_d   = valve_q;
		fwd_d     = fwd_q;
		waiting_d = waiting_q;
		elapsed_d = elapsed_q;
		resend_d  = resend_q;
		n_res     = 2'd0;
		res0      = '0;
		res1      = '0;
		case (req_s1.cmd)
			CMD_UP: begin
				if (!req_s1.short_frame) begin
					valve_d   = (digit != 4'd0);
					fwd_d     = rem100;
					waiting_d = 1'b1;
					elapsed_d = '0;
					resend_d  = '0;
					n_res     = 2'd2;
					res0      = '{dest: DEST_UP, value: valve_d ? OWN_ACK_ON : 16'd0,
						valve_open: valve_d, last: 1'b0};
					res1      = '{dest: DEST_DOWN, value: {9'd0, rem100},
						valve_open: valve_d, last: 1'b1};
				end
			end
			CMD_DOWN: begin
				if (!req_s1.short_frame) begin
					waiting_d = 1'b0;
					resend_d  = '0;
					if (req_s1.msg != 16'd0) begin
						n_res = 2'd1;
						res0  = '{dest: DEST_UP, value: own_ack + req_s1.msg,
							valve_open: valve_q, last: 1'b1};
					end
				end
			end
			CMD_TICK: begin
				if (waiting_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > {1'b0, resend_wait_q}) begin
						if (resend_q >= max_resends_q) begin
							waiting_d = 1'b0;
						end else begin
							resend_d  = resend_q + 4'd1;
							elapsed_d = '0;
							n_res     = 2'd1;
							res0      = '{dest: DEST_DOWN, value: {9'd0, fwd_q},
								valve_open: valve_q, last: 1'b1};
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q   <= 1'b0;
			fwd_q     <= '0;
			waiting_q <= 1'b0;
			elapsed_q <= '0;
			resend_q  <= '0;
		end else if (fire) begin
			valve_q   <= valve_d;
			fwd_q     <= fwd_d;
			waiting_q <= waiting_d;
			elapsed_q <= elapsed_d;
			resend_q  <= resend_d;
		end
	end

	assign n_push = fire ? n_res : 2'd0;
	assign n_pop  = rsp_take;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, n_pop};
			count_q  <= count_q + {1'b0, n_push} - {2'd0, n_pop};
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("output queue overflow");

	a_room_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (count_q - {2'd0, n_pop} + {1'b0, n_res}) <= 3'd4)
		else $error("request processed without queue room");

	a_wait_after_up: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.cmd == CMD_UP && !req_s1.short_frame)
			|=> (waiting_q && elapsed_q == 17'd0 && resend_q == 4'd0))
		else $error("upstream command did not start waiting");

	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.cmd == CMD_TICK && !waiting_q) |-> (n_res == 2'd0))
		else $error("tick produced a result while not waiting");

endmodule

[bench/valve_relay_ack_retry_unit_tb.sv]
// valve_relay_ack_retry_unit_tb: self-checking bench for the valve relay ack/retry unit
// a clocked driver and monitor around the dut, with a predictor of valve, forward and resend state
// depends on vrar_pkg and valve_relay_ack_retry_unit
module valve_relay_ack_retry_unit_tb;
	import vrar_pkg::*;

	localparam logic [1:0] CMD_NONE     = 2'd3;
	localparam int         DRAIN_CYCLES = 12;
	localparam int         LONG_HOLD    = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_RESEND_WAIT;
	logic [15:0] cfg_data = '0;

	valve_relay_ack_retry_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// relay state mirror
	logic        valve_on = 1'b0;
	logic [6:0]  fwd_val = '0;
	logic        waiting = 1'b0;
	logic [16:0] elapsed = '0;
	logic [3:0]  resends = '0;
	logic [15:0] resend_wait = RESEND_WAIT_RST;
	logic [3:0]  resend_limit = MAX_RESENDS_RST;

	req_t pending_reqs[$];
	rsp_t expected_sends[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int holds_asked = 0;
	int fail_cnt = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_resends = 0;
	int n_giveups = 0;
	int n_settings = 1;

	function automatic rsp_t make_send(logic dest, logic [15:0] value, logic last);
		rsp_t s;
		s.dest = dest;
		s.value = value;
		s.valve_open = valve_on;
		s.last = last;
		return s;
	endfunction

	function automatic void predict_relay_sends(req_t r);
		logic [15:0] own;
		logic [15:0] rem;
		case (r.cmd)
			CMD_UP: begin
				if (!r.short_frame) begin
					valve_on = ((r.msg / 16'd100) % 16'd10) != 16'd0;
					rem = r.msg % 16'd100;
					fwd_val = rem[6:0];
					waiting = 1'b1;
					elapsed = '0;
					resends = '0;
					own = valve_on ? OWN_ACK_ON : 16'd0;
					expected_sends.push_back(make_send(DEST_UP, own, 1'b0));
					expected_sends.push_back(make_send(DEST_DOWN, {9'd0, fwd_val}, 1'b1));
				end
			end
			CMD_DOWN: begin
				if (!r.short_frame) begin
					waiting = 1'b0;
					resends = '0;
					own = valve_on ? OWN_ACK_ON : 16'd0;
					if (r.msg != 16'd0)
						expected_sends.push_back(make_send(DEST_UP, own + r.msg, 1'b1));
				end
			end
			CMD_TICK: begin
				if (waiting) begin
					if (elapsed != ELAPSED_MAX)
						elapsed = elapsed + 17'd1;
					if (elapsed > {1'b0, resend_wait}) begin
						if (resends >= resend_limit) begin
							waiting = 1'b0;
							n_giveups++;
						end else begin
							resends = resends + 4'd1;
							elapsed = '0;
							expected_sends.push_back(make_send(DEST_DOWN, {9'd0, fwd_val}, 1'b1));
							n_resends++;
						end
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : req_driver
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_relay_sends(req_data);
				n_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_data <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with long hold-offs counted here
	int hold_left = 0;
	int holds_done = 0;
	always @(posedge clk or negedge arst_n) begin : rsp_staller
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_done + 1;
			hold_left <= LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : send_monitor
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_sends.size() == 0) begin
				$error("unexpected send: dest %0d value %0d", rsp_data.dest, rsp_data.value);
				fail_cnt++;
			end else begin
				want = expected_sends.pop_front();
				n_checked++;
				if (rsp_data.dest !== want.dest) begin
					$error("dest: expected %0d, got %0d", want.dest, rsp_data.dest);
					fail_cnt++;
				end
				if (rsp_data.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, rsp_data.value);
					fail_cnt++;
				end
				if (rsp_data.valve_open !== want.valve_open) begin
					$error("valve_open: expected %0d, got %0d", want.valve_open,
						rsp_data.valve_open);
					fail_cnt++;
				end
				if (rsp_data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_data.last);
					fail_cnt++;
				end
			end
		end
	end

	task automatic push_req(input logic [1:0] c, input logic [15:0] m, input logic s);
		req_t r;
		r.cmd = c;
		r.msg = m;
		r.short_frame = s;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_valid || expected_sends.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_RESEND_WAIT)
			resend_wait = val;
		else
			resend_limit = val[3:0];
		@(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] tmo, input logic [3:0] lim);
		wait_idle();
		write_reg(REG_RESEND_WAIT, tmo);
		write_reg(REG_MAX_RESENDS, {12'd0, lim});
		n_settings++;
	endtask

	// one upstream command, some ticks and usually a downstream ack; sometimes noise
	task automatic push_exchange(output int n);
		int span;
		int ticks;
		n = 0;
		if ($urandom_range(9) == 0) begin
			push_req(2'($urandom_range(3)), 16'($urandom), 1'($urandom));
			n = 1;
		end else begin
			push_req(CMD_UP, 16'($urandom), $urandom_range(7) == 0);
			n++;
			span = (int'(resend_wait) + 1) * (int'(resend_limit) + 2);
			if (span > 60)
				span = 60;
			ticks = $urandom_range(span);
			repeat (ticks) begin
				push_req(CMD_TICK, 16'($urandom), 1'($urandom));
				n++;
			end
			if ($urandom_range(3) != 0) begin
				push_req(CMD_DOWN, ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom),
					$urandom_range(9) == 0);
				n++;
			end
		end
	endtask

	task automatic run_phase(input logic [15:0] tmo, input logic [3:0] lim,
		input int sidle, input int spct, input int count, input bit long_hold,
		input bit pause_mid);
		int pushed;
		int k;
		set_config(tmo, lim);
		send_idle_pct = sidle;
		stall_pct = spct;
		if (long_hold)
			holds_asked++;
		pushed = 0;
		while (pushed < count) begin
			if (pause_mid && pushed >= count / 2) begin
				wait_idle();
				pause_mid = 0;
			end
			push_exchange(k);
			pushed += k;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// reset settings: ack values, wrap, digit extraction, ignored frames
		push_req(CMD_DOWN, 16'd0, 1'b0);
		push_req(CMD_DOWN, 16'd5, 1'b0);
		push_req(CMD_TICK, 16'hFFFF, 1'b0);
		push_req(CMD_NONE, 16'h1234, 1'b0);
		push_req(CMD_UP, 16'd0, 1'b0);
		push_req(CMD_UP, 16'hFFFF, 1'b0);
		push_req(CMD_DOWN, 16'hFFFF, 1'b0);
		push_req(CMD_UP, 16'd900, 1'b1);
		push_req(CMD_DOWN, 16'd77, 1'b1);
		push_req(CMD_UP, 16'd1000, 1'b0);
		push_req(CMD_UP, 16'd199, 1'b0);
		push_req(CMD_TICK, 16'd0, 1'b1);
		push_req(CMD_DOWN, 16'd0, 1'b0);

		// timeout of 1 with no resends: give up on the second tick
		set_config(16'd1, 4'd0);
		push_req(CMD_UP, 16'd250, 1'b0);
		push_req(CMD_TICK, 16'd0, 1'b0);
		push_req(CMD_TICK, 16'd0, 1'b0);
		push_req(CMD_TICK, 16'd0, 1'b0);
		push_req(CMD_DOWN, 16'd7, 1'b0);

		run_phase(16'd1, 4'd15, 0, 0, 80, 1'b0, 1'b0);
		run_phase(16'd2, 4'd3, 62, 0, 70, 1'b0, 1'b0);
		run_phase(16'd3, 4'd0, 0, 62, 70, 1'b0, 1'b0);
		run_phase(16'hFFFF, 4'd5, 62, 62, 40, 1'b0, 1'b0);
		run_phase(16'd1, 4'd2, 0, 0, 70, 1'b1, 1'b0);
		run_phase(16'd4, 4'd7, 28, 28, 70, 1'b0, 1'b1);
		wait_idle();

		$display("%0d requests over %0d register settings, %0d sends checked",
			n_accepted, n_settings, n_checked);
		$display("%0d resends and %0d give-ups on the downstream node", n_resends, n_giveups);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/vrar_pkg.sv
hw/rtl/valve_relay_ack_retry_unit.sv
bench/valve_relay_ack_retry_unit_tb.sv
